[sv/deadline_sorted_task_queue_assert.svh]
// assertion macros used by the checker file of the task queue
`ifndef DEADLINE_SORTED_TASK_QUEUE_ASSERT_SVH
`define DEADLINE_SORTED_TASK_QUEUE_ASSERT_SVH

// property checked on every rising edge, held off while reset is high
`define DSTQ_ASSERT(name, clk, rst, prop) \
   name: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("dstq assertion failed");

// property checked on every rising edge, reset included
`define DSTQ_ASSERT_ALWAYS(name, clk, prop) \
   name: assert property (@(posedge clk) prop) \
      else $error("dstq assertion failed");

`endif

[sv/dstq_pkg.sv]
// shared types and codes of the deadline sorted task queue
`default_nettype none

package dstq_pkg;

   localparam int TASK_W  = 8;
   localparam int DL_W    = 32;
   localparam int COUNT_W = 5;
   localparam int STAT_W  = 2;

   localparam logic OP_INSERT = 1'b0;
   localparam logic OP_REMOVE = 1'b1;

   localparam logic [STAT_W-1:0] STATUS_DONE = 2'd0;
   localparam logic [STAT_W-1:0] STATUS_FULL = 2'd1;
   localparam logic [STAT_W-1:0] STATUS_MISS = 2'd2;

   typedef struct packed {
      logic [STAT_W-1:0]  status;
      logic [TASK_W-1:0]  head_task;
      logic [DL_W-1:0]    head_deadline;
      logic [COUNT_W-1:0] entry_count;
      logic               is_empty;
   } rsp_type;

endpackage

`default_nettype wire

[sv/dstq_mem.sv]
// entry store: one write port, one read port with registered read data
`default_nettype none

module dstq_mem #(
   parameter int DEPTH = 16,
   parameter int AW    = 4,
   parameter int WIDTH = 40
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic             re,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

[sv/dstq_ctrl.sv]
// sequencer that walks the entry store with one compare unit per step
`default_nettype none

module dstq_ctrl
   import dstq_pkg::*;
#(
   parameter int DEPTH = 16,
   parameter int AW    = 4,
   parameter int CW    = 5,
   parameter int IDW   = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic              req_op,
   input  logic [IDW-1:0]    req_task,
   input  logic [DL_W-1:0]   req_dl,
   input  logic              out_free,
   output logic              rsp_load,
   output rsp_type           rsp_info,
   output logic              mem_we,
   output logic [AW-1:0]     mem_waddr,
   output logic [IDW+DL_W-1:0] mem_wdata,
   output logic              mem_re,
   output logic [AW-1:0]     mem_raddr,
   input  logic [IDW+DL_W-1:0] mem_rdata
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_INS_WALK,
      ST_INS_PUT,
      ST_REM_WALK,
      ST_HEAD,
      ST_DONE
   } state_type;

   state_type         state_ff, state_in;
   logic [CW-1:0]     occ_ff, occ_in;
   logic [AW-1:0]     idx_ff, idx_in;
   logic              found_ff, found_in;
   logic [STAT_W-1:0] status_ff, status_in;
   logic [IDW-1:0]    task_ff, task_in;
   logic [DL_W-1:0]   dl_ff, dl_in;

   logic [IDW-1:0]    rd_task;
   logic [DL_W-1:0]   rd_dl;
   logic              dl_later;
   logic              id_match;
   logic [AW-1:0]     last_idx;
   logic [IDW+TASK_W-1:0] task_ext;
   logic [CW+COUNT_W-1:0] count_ext;

   assign rd_task  = mem_rdata[IDW-1:0];
   assign rd_dl    = mem_rdata[IDW+DL_W-1:IDW];
   // the shared compare unit
   assign dl_later = rd_dl > dl_ff;
   assign id_match = rd_task == task_ff;
   assign last_idx = AW'(occ_ff - 1'b1);

   assign req_ready = state_ff == ST_IDLE;
   assign rsp_load  = (state_ff == ST_DONE) && out_free;

   assign task_ext  = {{TASK_W{1'b0}}, rd_task};
   assign count_ext = {{COUNT_W{1'b0}}, occ_ff};

   always_comb begin
      rsp_info.status        = status_ff;
      rsp_info.entry_count   = count_ext[COUNT_W-1:0];
      rsp_info.is_empty      = occ_ff == '0;
      rsp_info.head_task     = '0;
      rsp_info.head_deadline = '0;
      if (occ_ff != '0) begin
         rsp_info.head_task     = task_ext[TASK_W-1:0];
         rsp_info.head_deadline = rd_dl;
      end
   end

   always_comb begin
      state_in  = state_ff;
      occ_in    = occ_ff;
      idx_in    = idx_ff;
      found_in  = found_ff;
      status_in = status_ff;
      task_in   = task_ff;
      dl_in     = dl_ff;
      mem_we    = 1'b0;
      mem_waddr = idx_ff;
      mem_wdata = mem_rdata;
      mem_re    = 1'b0;
      mem_raddr = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               task_in   = req_task;
               dl_in     = req_dl;
               status_in = STATUS_DONE;
               found_in  = 1'b0;
               if (req_op == OP_INSERT) begin
                  if (occ_ff == CW'(DEPTH)) begin
                     status_in = STATUS_FULL;
                     state_in  = ST_HEAD;
                  end else if (occ_ff == '0) begin
                     idx_in   = '0;
                     state_in = ST_INS_PUT;
                  end else begin
                     // walk from the tail toward the front
                     mem_re    = 1'b1;
                     mem_raddr = last_idx;
                     idx_in    = AW'(occ_ff);
                     state_in  = ST_INS_WALK;
                  end
               end else begin
                  if (occ_ff == '0) begin
                     status_in = STATUS_MISS;
                     state_in  = ST_HEAD;
                  end else begin
                     mem_re    = 1'b1;
                     mem_raddr = '0;
                     idx_in    = '0;
                     state_in  = ST_REM_WALK;
                  end
               end
            end
         end
         ST_INS_WALK: begin
            // read data holds entry idx-1
            if (dl_later) begin
               mem_we    = 1'b1;
               mem_waddr = idx_ff;
               mem_wdata = mem_rdata;
               idx_in    = idx_ff - 1'b1;
               if (idx_ff == AW'(1)) begin
                  state_in = ST_INS_PUT;
               end else begin
                  mem_re    = 1'b1;
                  mem_raddr = idx_ff - AW'(2);
               end
            end else begin
               state_in = ST_INS_PUT;
            end
         end
         ST_INS_PUT: begin
            mem_we    = 1'b1;
            mem_waddr = idx_ff;
            mem_wdata = {dl_ff, task_ff};
            occ_in    = occ_ff + 1'b1;
            state_in  = ST_HEAD;
         end
         ST_REM_WALK: begin
            // read data holds entry idx; after the match every entry moves up one
            if (found_ff) begin
               mem_we    = 1'b1;
               mem_waddr = idx_ff - 1'b1;
               mem_wdata = mem_rdata;
            end
            found_in = found_ff || id_match;
            if (idx_ff == last_idx) begin
               if (found_ff || id_match) begin
                  occ_in = occ_ff - 1'b1;
               end else begin
                  status_in = STATUS_MISS;
               end
               state_in = ST_HEAD;
            end else begin
               mem_re    = 1'b1;
               mem_raddr = idx_ff + 1'b1;
               idx_in    = idx_ff + 1'b1;
            end
         end
         ST_HEAD: begin
            mem_re    = 1'b1;
            mem_raddr = '0;
            state_in  = ST_DONE;
         end
         ST_DONE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         occ_ff   <= '0;
         found_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         occ_ff   <= occ_in;
         found_ff <= found_in;
      end
      idx_ff    <= idx_in;
      status_ff <= status_in;
      task_ff   <= task_in;
      dl_ff     <= dl_in;
   end

endmodule

`default_nettype wire

[sv/deadline_sorted_task_queue.sv]
// Deadline sorted task queue, earliest deadline at the head.
//
// req channel: one transfer per command. tuser is the opcode (insert or
// remove); tdata carries the task id and, for inserts, the deadline.
// rsp channel: exactly one transfer per command with the status, the head
// task and deadline, the entry count and an empty flag.
//
// Entries live in a single-port-read, single-port-write store that the
// sequencer walks one entry per cycle with one compare unit. An insert
// walks past every entry with a later deadline, stops at an entry with an
// earlier or equal deadline, writes the new entry and reads the head; a
// remove walks every held entry, moving those after the match up one, and
// then reads the head; a full insert or an empty remove reads only the
// head. The sequencer then hands the result to the output register.
// req_tready is high only while the sequencer is idle.
//
// Reset empties the queue at once; stored entries are not cleared. The
// result sits in an output register, so a stalled receiver holds rsp_tdata
// steady while the next command is already accepted and processed; that
// command then waits with its result until the register frees up.
`default_nettype none

module deadline_sorted_task_queue
   import dstq_pkg::*;
#(
   parameter int DEPTH   = 16,
   parameter int ID_BITS = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // task_id[7:0], deadline[39:8]
   input  logic        req_tuser,   // op[0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,   // head_task[7:0], head_deadline[39:8],
                                    // entry_count[44:40], is_empty[45], zero[47:46]
   output logic [1:0]  rsp_tuser    // status[1:0]
);

   localparam int AW  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW  = $clog2(DEPTH + 1);
   localparam int IDW = (ID_BITS < TASK_W) ? ID_BITS : TASK_W;
   localparam int MW  = IDW + DL_W;

   logic          out_free;
   logic          rsp_load;
   rsp_type       rsp_info;
   logic          mem_we;
   logic [AW-1:0] mem_waddr;
   logic [MW-1:0] mem_wdata;
   logic          mem_re;
   logic [AW-1:0] mem_raddr;
   logic [MW-1:0] mem_rdata;

   logic          rsp_valid_ff, rsp_valid_in;
   rsp_type       rsp_data_ff, rsp_data_in;

   dstq_mem #(
      .DEPTH (DEPTH),
      .AW    (AW),
      .WIDTH (MW)
   ) u_mem (
      .clock (clock),
      .we    (mem_we),
      .waddr (mem_waddr),
      .wdata (mem_wdata),
      .re    (mem_re),
      .raddr (mem_raddr),
      .rdata (mem_rdata)
   );

   dstq_ctrl #(
      .DEPTH (DEPTH),
      .AW    (AW),
      .CW    (CW),
      .IDW   (IDW)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .req_op    (req_tuser),
      .req_task  (req_tdata[IDW-1:0]),
      .req_dl    (req_tdata[TASK_W+DL_W-1:TASK_W]),
      .out_free  (out_free),
      .rsp_load  (rsp_load),
      .rsp_info  (rsp_info),
      .mem_we    (mem_we),
      .mem_waddr (mem_waddr),
      .mem_wdata (mem_wdata),
      .mem_re    (mem_re),
      .mem_raddr (mem_raddr),
      .mem_rdata (mem_rdata)
   );

   assign out_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = rsp_info;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_data_ff.status;
   assign rsp_tdata  = {2'b00, rsp_data_ff.is_empty, rsp_data_ff.entry_count,
                        rsp_data_ff.head_deadline, rsp_data_ff.head_task};

endmodule

`default_nettype wire

[sv/dstq_checker.sv]
// port-level checks of the task queue, bound to the top level
`default_nettype none

`include "deadline_sorted_task_queue_assert.svh"

module dstq_checker
   import dstq_pkg::*;
(
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tvalid,
   input wire logic        req_tready,
   input wire logic [39:0] req_tdata,
   input wire logic        req_tuser,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [47:0] rsp_tdata,
   input wire logic [1:0]  rsp_tuser
);

   // stalled result holds
   `DSTQ_ASSERT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))

   // an empty queue reports a zero head and a zero count
   `DSTQ_ASSERT(a_empty_zero, clock, reset, rsp_tvalid && rsp_tdata[45] |-> rsp_tdata[44:0] == 45'd0)

   // a dropped insert means the queue holds entries
   `DSTQ_ASSERT(a_full_not_empty, clock, reset, rsp_tvalid && rsp_tuser == STATUS_FULL |-> !rsp_tdata[45])

   // the sequencer is busy right after taking a command
   `DSTQ_ASSERT(a_busy_after_take, clock, reset, req_tvalid && req_tready |=> !req_tready)

   // no result is shown right after reset
   `DSTQ_ASSERT_ALWAYS(a_reset_quiet, clock, reset |=> !rsp_tvalid)

endmodule

bind deadline_sorted_task_queue dstq_checker u_dstq_checker (.*);

`default_nettype wire

[tb/sv/tb.sv]
// self-checking testbench for the deadline sorted task queue
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import dstq_pkg::*;

   localparam int QUEUE_DEPTH = 16;
   localparam int HOLD_CYCLES = 300;
   localparam int CYCLE_LIMIT = 600000;
   localparam int SETTLE_CYCLES = 2 * (QUEUE_DEPTH + 4);

   // shadow of the sorted queue and the results still to come
   class queue_tracker;
      logic [TASK_W-1:0] held_task[QUEUE_DEPTH];
      logic [DL_W-1:0]   held_deadline[QUEUE_DEPTH];
      int                held_count = 0;
      rsp_type           awaited_rsp[$];
      int                mismatches = 0;

      function void note_command(logic op, logic [TASK_W-1:0] id, logic [DL_W-1:0] dl);
         rsp_type r;
         int pos;
         r.status = STATUS_DONE;
         pos = 0;
         if (op == OP_INSERT) begin
            if (held_count >= QUEUE_DEPTH) begin
               r.status = STATUS_FULL;
            end else begin
               // equal deadlines keep arrival order
               while (pos < held_count && held_deadline[pos] <= dl) pos++;
               for (int k = held_count; k > pos; k--) begin
                  held_task[k]     = held_task[k-1];
                  held_deadline[k] = held_deadline[k-1];
               end
               held_task[pos]     = id;
               held_deadline[pos] = dl;
               held_count++;
            end
         end else begin
            while (pos < held_count && held_task[pos] != id) pos++;
            if (pos >= held_count) begin
               r.status = STATUS_MISS;
            end else begin
               for (int k = pos; k + 1 < held_count; k++) begin
                  held_task[k]     = held_task[k+1];
                  held_deadline[k] = held_deadline[k+1];
               end
               held_count--;
            end
         end
         r.entry_count   = COUNT_W'(held_count);
         r.is_empty      = (held_count == 0);
         r.head_task     = (held_count > 0) ? held_task[0] : '0;
         r.head_deadline = (held_count > 0) ? held_deadline[0] : '0;
         awaited_rsp.push_back(r);
      endfunction

      function void compare_field(string name, longint unsigned want, longint unsigned got);
         if (want != got) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            mismatches++;
         end
      endfunction

      function void check_result(logic [47:0] data, logic [1:0] user);
         rsp_type want;
         if (awaited_rsp.size() == 0) begin
            $error("result transfer with nothing outstanding, tdata %h", data);
            mismatches++;
            return;
         end
         want = awaited_rsp.pop_front();
         compare_field("status", want.status, user);
         compare_field("head_task", want.head_task, data[7:0]);
         compare_field("head_deadline", want.head_deadline, data[39:8]);
         compare_field("entry_count", want.entry_count, data[44:40]);
         compare_field("is_empty", want.is_empty, data[45]);
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [39:0] req_tdata = '0;   // task_id[7:0], deadline[39:8]
   logic        req_tuser = 1'b0; // op[0]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [47:0] rsp_tdata;        // head_task, head_deadline, entry_count, is_empty
   logic [1:0]  rsp_tuser;        // status[1:0]

   queue_tracker tracker = new();
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int hold_asks = 0;
   int hold_seen = 0;
   int hold_left = 0;
   int cycle_count = 0;

   deadline_sorted_task_queue #(
      .DEPTH   (QUEUE_DEPTH),
      .ID_BITS (TASK_W)
   ) i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #1 clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   // result side: check each transfer, then pick the next ready
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) tracker.check_result(rsp_tdata, rsp_tuser);
         if (hold_seen != hold_asks) begin
            hold_seen = hold_asks;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   // valid stays high after a transfer; the next call lowers it only to idle
   task automatic send_item(input logic op, input logic [TASK_W-1:0] id,
                            input logic [DL_W-1:0] dl);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {dl, id};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      tracker.note_command(op, id, dl);
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (tracker.awaited_rsp.size() != 0);
   endtask

   task automatic random_commands(input int count);
      int insert_pct;
      int pick;
      logic op;
      logic [TASK_W-1:0] id;
      logic [DL_W-1:0] dl;
      insert_pct = 50;
      for (int n = 0; n < count; n++) begin
         // drift the fill level so full and empty queues both come up
         if (n % 80 == 0) begin
            pick = $urandom_range(3);
            insert_pct = (pick == 0) ? 25 : (pick == 1) ? 50 : (pick == 2) ? 75 : 95;
         end
         op = ($urandom_range(99) < insert_pct) ? OP_INSERT : OP_REMOVE;
         if (op == OP_REMOVE && tracker.held_count > 0 && $urandom_range(99) < 80)
            id = tracker.held_task[$urandom_range(tracker.held_count - 1)];
         else if ($urandom_range(99) < 40)
            id = TASK_W'($urandom_range(7));
         else
            id = TASK_W'($urandom_range(255));
         case ($urandom_range(9))
            0: dl = '0;
            1: dl = '1;
            2, 3: dl = $urandom_range(15);
            4: dl = (tracker.held_count > 0) ?
                    tracker.held_deadline[$urandom_range(tracker.held_count - 1)] :
                    $urandom;
            default: dl = $urandom;
         endcase
         send_item(op, id, dl);
      end
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      send_idle_pct = 30;
      recv_idle_pct = 45;

      // directed: empty remove, front/back inserts, ties, duplicate ids, full
      send_item(OP_REMOVE, 8'd5, 32'h0);
      send_item(OP_INSERT, 8'd0, 32'd100);
      send_item(OP_INSERT, 8'd255, 32'hFFFF_FFFF);
      send_item(OP_INSERT, 8'd1, 32'd0);
      send_item(OP_INSERT, 8'd2, 32'd100);
      send_item(OP_INSERT, 8'd3, 32'd100);
      send_item(OP_INSERT, 8'd0, 32'd50);
      send_item(OP_REMOVE, 8'd0, 32'hFFFF_FFFF);
      send_item(OP_REMOVE, 8'd1, 32'h0);
      for (int k = 0; k < 11; k++)
         send_item(OP_INSERT, 8'hA0 + k[7:0],
                   (k % 2 == 0) ? k * 1000 : 32'hFFFF_FFFF - k);
      send_item(OP_INSERT, 8'd77, 32'd7);
      send_item(OP_REMOVE, 8'd77, 32'h0);
      send_item(OP_REMOVE, 8'd255, 32'h0);

      random_commands(610);
      wait_drained();

      send_idle_pct = 45;
      recv_idle_pct = 30;
      random_commands(610);
      wait_drained();

      // no idling, but a long receiver stall first so the input backs up
      send_idle_pct = 0;
      recv_idle_pct = 0;
      hold_asks++;
      random_commands(610);
      wait_drained();

      repeat (SETTLE_CYCLES) @(posedge clock);
      if (tracker.mismatches == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
